// File: hw/rtl/aes128_pkg.sv
// ============================================================================
// AES-128 package
// S-boxes, GF(2^8) helpers and the shared types and codes of the cipher.
// ============================================================================
package aes128_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_state;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;
    localparam int   CFG_IDX_W    = 1;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic t_byte xt(input t_byte a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gmul(input t_byte a, input logic [3:0] b);
        t_byte p, x;
        p = '0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p ^= x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    // byte i of the state sits at bits 127-8i:120-8i
    function automatic t_byte get_b(input t_state s, input int i);
        get_b = s[127 - 8*i -: 8];
    endfunction

    function automatic t_state sub_shift(input t_state s);
        t_state o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*c) -: 8] = SBOX[get_b(s, r + 4*((c + r) & 3))];
        sub_shift = o;
    endfunction

    function automatic t_state inv_shift_sub(input t_state s);
        t_state o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*((c + r) & 3)) -: 8] = ISBOX[get_b(s, r + 4*c)];
        inv_shift_sub = o;
    endfunction

    function automatic t_state mix(input t_state s, input logic inv);
        t_state o;
        t_byte  t [4];
        logic [3:0] m [4];
        if (inv) begin
            m[0] = 4'he; m[1] = 4'hb; m[2] = 4'hd; m[3] = 4'h9;
        end else begin
            m[0] = 4'h2; m[1] = 4'h3; m[2] = 4'h1; m[3] = 4'h1;
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) t[k] = get_b(s, 4*c + k);
            for (int r = 0; r < 4; r++) begin
                o[127 - 8*(4*c + r) -: 8] = gmul(t[0], m[(0 - r + 4) & 3]) ^
                    gmul(t[1], m[(1 - r + 4) & 3]) ^ gmul(t[2], m[(2 - r + 4) & 3]) ^
                    gmul(t[3], m[(3 - r + 4) & 3]);
            end
        end
        mix = o;
    endfunction

    function automatic t_word sub_word(input t_word w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: hw/rtl/aes128_block_cipher_top.sv
// ============================================================================
// AES-128 block cipher top level
// Key expansion sequencer and an unrolled round pipeline, encrypt or decrypt.
// ============================================================================
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_kind, i_block_high, i_block_low
//  result  | out       | o_valid / i_stall  | o_out_high, o_out_low
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One block per cycle unless a key expansion or an output stall holds the
// input; one stage per round plus input and output registers. A key write
// runs the key expansion, one round-key word per cycle, during which no block is
// accepted. Reset clears all valid bits and expands the zero key. An output stall
// with a valid result freezes the whole pipeline, so nothing is lost or repeated.
module aes128_block_cipher_top
    import aes128_pkg::*;
#(
    parameter int ROUNDS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [63:0]          i_block_high,
    input  logic [63:0]          i_block_low,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_out_high,
    output logic [63:0]          o_out_low,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam int NWORDS = 4 * (ROUNDS + 1);
    localparam int WIDX_W = $clog2(NWORDS + 1);

    logic [63:0]       r_key_high, r_key_low;
    logic [31:0]       r_rk [NWORDS];
    logic [WIDX_W-1:0] r_widx;
    logic              r_busy;
    logic [7:0]        r_rc;
    logic [31:0]       w_prev, w_t;

    logic              adv;
    logic              r_v  [ROUNDS+2];
    logic              r_k  [ROUNDS+1];
    t_state            r_s  [ROUNDS+2];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy | (r_v[ROUNDS+1] & i_stall);
    assign adv         = !(r_v[ROUNDS+1] & i_stall);

    // key expansion sequencer
    assign w_prev = r_rk[r_widx[WIDX_W-1:0] - WIDX_W'(1)];
    always_comb begin
        w_t = w_prev;
        if (r_widx[1:0] == 2'd0)
            w_t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rc, 24'h0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_busy     <= 1'b1;
            r_widx     <= WIDX_W'(4);
            r_rc       <= 8'h01;
            r_rk[0] <= '0; r_rk[1] <= '0; r_rk[2] <= '0; r_rk[3] <= '0;
        end else if (i_cfg_valid) begin
            r_busy <= 1'b1;
            r_widx <= WIDX_W'(4);
            r_rc   <= 8'h01;
            if (i_cfg_index == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
                r_rk[0] <= i_cfg_data[63:32]; r_rk[1] <= i_cfg_data[31:0];
                r_rk[2] <= r_key_low[63:32];  r_rk[3] <= r_key_low[31:0];
            end else begin
                r_key_low <= i_cfg_data;
                r_rk[0] <= r_key_high[63:32]; r_rk[1] <= r_key_high[31:0];
                r_rk[2] <= i_cfg_data[63:32]; r_rk[3] <= i_cfg_data[31:0];
            end
        end else if (r_busy) begin
            r_rk[r_widx] <= r_rk[r_widx - WIDX_W'(4)] ^ w_t;
            if (r_widx[1:0] == 2'd0) r_rc <= xt(r_rc);
            if (r_widx == WIDX_W'(NWORDS - 1)) r_busy <= 1'b0;
            r_widx <= r_widx + WIDX_W'(1);
        end
    end

    function automatic t_state rkey(input int r);
        rkey = {r_rk[4*r], r_rk[4*r+1], r_rk[4*r+2], r_rk[4*r+3]};
    endfunction

    // stage 0: initial key add; stages 1..ROUNDS: one round each; stage ROUNDS+1: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROUNDS + 2; i++) r_v[i] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid & !r_busy;
            for (int i = 1; i < ROUNDS + 2; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k[0] <= i_kind;
            r_s[0] <= {i_block_high, i_block_low} ^
                      rkey(i_kind == KIND_DEC ? ROUNDS : 0);
            for (int i = 1; i <= ROUNDS; i++) begin
                r_k[i] <= r_k[i-1];
                if (r_k[i-1] == KIND_ENC) begin
                    if (i == ROUNDS) r_s[i] <= sub_shift(r_s[i-1]) ^ rkey(i);
                    else r_s[i] <= mix(sub_shift(r_s[i-1]), 1'b0) ^ rkey(i);
                end else begin
                    if (i == ROUNDS) r_s[i] <= inv_shift_sub(r_s[i-1]) ^ rkey(0);
                    else r_s[i] <= mix(inv_shift_sub(r_s[i-1]) ^ rkey(ROUNDS - i), 1'b1);
                end
            end
            r_s[ROUNDS+1] <= r_s[ROUNDS];
        end
    end

    assign o_valid    = r_v[ROUNDS+1];
    assign o_out_high = r_s[ROUNDS+1][127:64];
    assign o_out_low  = r_s[ROUNDS+1][63:0];

endmodule

// File: hw/rtl/aes128_chk.sv
// ============================================================================
// AES-128 port checker
// Handshake and key-load properties seen at the top-level ports.
// ============================================================================
module aes128_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_out_high,
    input logic        i_cfg_valid
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_high)) else $error("result dropped");
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall) else $error("accepted into full pipe");
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> o_stall) else $error("request taken during key expansion");
endmodule

bind aes128_block_cipher_top aes128_chk u_chk (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_out_high, .i_cfg_valid
);
